FILE: rtl/core/ffpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpc_pkg
// Shared types, register indexes and rule tables for the fire pixel classifier.
// ----------------------------------------------------------------------------
package ffpc_pkg;

   localparam int LEVEL_W     = 8;
   localparam int THRESH_W    = 7;
   localparam int SCORE_W     = 8;
   localparam int WEIGHT_W    = 4;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_MAX = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD = 1'd1;

   localparam logic [LEVEL_W-1:0]  FRAME_MAX_RESET = 8'd255;
   localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 7'd60;

   // rule that fires for a pixel; at most one can, since each difference
   // is either low, high or neither
   typedef enum logic [2:0] {
      RULE_NONE,
      RULE_LOW_LOW,
      RULE_LOW_HIGH,
      RULE_HIGH_LOW,
      RULE_HIGH_HIGH
   } rule_type;

   // centroid weight of the rule, in tenths
   function automatic logic [WEIGHT_W-1:0] rule_weight(input rule_type rule);
      logic [WEIGHT_W-1:0] w;
      w = '0;
      unique case (rule)
         RULE_LOW_HIGH:  w = 4'd3;
         RULE_HIGH_LOW:  w = 4'd5;
         RULE_HIGH_HIGH: w = 4'd10;
         default:        w = '0;
      endcase
      return w;
   endfunction

   // floor(256 * weight / 10), saturated
   function automatic logic [SCORE_W-1:0] rule_score(input rule_type rule);
      logic [SCORE_W-1:0] s;
      s = '0;
      unique case (rule)
         RULE_LOW_HIGH:  s = 8'd76;
         RULE_HIGH_LOW:  s = 8'd128;
         RULE_HIGH_HIGH: s = 8'd255;
         default:        s = '0;
      endcase
      return s;
   endfunction

endpackage

FILE: rtl/core/fuzzy_fire_pixel_classifier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuzzy_fire_pixel_classifier_top
// Fuzzy YCbCr fire pixel classifier: flag and score for one pixel per cycle.
// ----------------------------------------------------------------------------
// Pipeline: three register stages (differences, memberships, defuzzify) lie
// between a req transaction and its rsp transaction.
// Throughput: one pixel per cycle; a stall on rsp holds the output stage and
// earlier stages fill empty slots until all three are full, and the output
// stage frees its slot in the same cycle it is taken.
// Reset: synchronous, active high; clears all stage valid bits and loads
// frame_max = 255 and threshold = 60 hundredths.
// ----------------------------------------------------------------------------
module fuzzy_fire_pixel_classifier_top (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] y_level, [15:8] cr_level, [23:16] cb_level
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] fire_score
   output logic [0:0]  rsp_tuser,   // [0] fire_flag
   // configuration writes
   input  logic                                 csr_we,
   input  logic [ffpc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ffpc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // -------------------------------------------------------------------------
   // Configuration registers
   // -------------------------------------------------------------------------
   logic [ffpc_pkg::LEVEL_W-1:0]  frame_max_ff;
   logic [ffpc_pkg::THRESH_W-1:0] threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_max_ff <= ffpc_pkg::FRAME_MAX_RESET;
         threshold_ff <= ffpc_pkg::THRESHOLD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            ffpc_pkg::CSR_FRAME_MAX: frame_max_ff <= csr_wdata[ffpc_pkg::LEVEL_W-1:0];
            ffpc_pkg::CSR_THRESHOLD: threshold_ff <= csr_wdata[ffpc_pkg::THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Stage handshake: a stage takes new data when it is empty or when the
   // stage after it moves on in the same cycle.
   // -------------------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff;
   logic ready1, ready2, ready3;

   assign ready3     = !v3_ff || rsp_tready;
   assign ready2     = !v2_ff || ready3;
   assign ready1     = !v1_ff || ready2;
   assign req_tready = ready1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (ready1) v1_ff <= req_tvalid;
         if (ready2) v2_ff <= v1_ff;
         if (ready3) v3_ff <= v2_ff;
      end
   end

   // -------------------------------------------------------------------------
   // Stage 1: form D1 = Y - Cb and D2 = Cr - Cb, kept as sign and magnitude.
   // Both lie in -255..255, so the magnitude fits 8 bits.
   // -------------------------------------------------------------------------
   logic [ffpc_pkg::LEVEL_W-1:0] y_lvl, cr_lvl, cb_lvl;
   logic signed [ffpc_pkg::LEVEL_W:0] d1, d2, d1_neg, d2_neg;

   logic                         d1_sign_ff, d2_sign_ff, d1_sign_in, d2_sign_in;
   logic [ffpc_pkg::LEVEL_W-1:0] d1_mag_ff, d2_mag_ff, d1_mag_in, d2_mag_in;

   assign y_lvl  = req_tdata[7:0];
   assign cr_lvl = req_tdata[15:8];
   assign cb_lvl = req_tdata[23:16];

   always_comb begin
      d1         = $signed({1'b0, y_lvl}) - $signed({1'b0, cb_lvl});
      d2         = $signed({1'b0, cr_lvl}) - $signed({1'b0, cb_lvl});
      d1_neg     = -d1;
      d2_neg     = -d2;
      d1_sign_in = d1[ffpc_pkg::LEVEL_W];
      d2_sign_in = d2[ffpc_pkg::LEVEL_W];
      d1_mag_in  = d1_sign_in ? d1_neg[ffpc_pkg::LEVEL_W-1:0] : d1[ffpc_pkg::LEVEL_W-1:0];
      d2_mag_in  = d2_sign_in ? d2_neg[ffpc_pkg::LEVEL_W-1:0] : d2[ffpc_pkg::LEVEL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ready1 && req_tvalid) begin
         d1_sign_ff <= d1_sign_in;
         d2_sign_ff <= d2_sign_in;
         d1_mag_ff  <= d1_mag_in;
         d2_mag_ff  <= d2_mag_in;
      end
   end

   // -------------------------------------------------------------------------
   // Stage 2: memberships. A triangle is nonzero only strictly inside (-M,0)
   // for low and (0,M) for high, so a difference is low, high or neither.
   // A min rule fires when both of its memberships are nonzero; at most one
   // rule can fire, which makes the centroid that rule's weight alone.
   // -------------------------------------------------------------------------
   logic d1_act, d2_act, lo1, hi1, lo2, hi2;
   ffpc_pkg::rule_type rule_ff, rule_in;

   always_comb begin
      d1_act = (d1_mag_ff != '0) && (d1_mag_ff < frame_max_ff);
      d2_act = (d2_mag_ff != '0) && (d2_mag_ff < frame_max_ff);
      lo1    = d1_act &&  d1_sign_ff;
      hi1    = d1_act && !d1_sign_ff;
      lo2    = d2_act &&  d2_sign_ff;
      hi2    = d2_act && !d2_sign_ff;
      if      (lo1 && lo2) rule_in = ffpc_pkg::RULE_LOW_LOW;
      else if (lo1 && hi2) rule_in = ffpc_pkg::RULE_LOW_HIGH;
      else if (hi1 && lo2) rule_in = ffpc_pkg::RULE_HIGH_LOW;
      else if (hi1 && hi2) rule_in = ffpc_pkg::RULE_HIGH_HIGH;
      else                 rule_in = ffpc_pkg::RULE_NONE;
   end

   always_ff @(posedge clock) begin
      if (ready2 && v1_ff) rule_ff <= rule_in;
   end

   // -------------------------------------------------------------------------
   // Stage 3: defuzzify. Since num = w*r and den = r, the flag compare
   // 10*num > T*den reduces to 10*w > T, and the score is a fixed value per
   // rule. No rule firing gives flag 0 and score 0.
   // -------------------------------------------------------------------------
   logic [ffpc_pkg::WEIGHT_W-1:0] weight;
   logic [ffpc_pkg::THRESH_W-1:0] weight_x10;
   logic                          flag_ff, flag_in;
   logic [ffpc_pkg::SCORE_W-1:0]  score_ff, score_in;

   always_comb begin
      weight     = ffpc_pkg::rule_weight(rule_ff);
      weight_x10 = ffpc_pkg::THRESH_W'({weight, 3'b000}) + ffpc_pkg::THRESH_W'({weight, 1'b0});
      flag_in    = (rule_ff != ffpc_pkg::RULE_NONE) && (weight_x10 > threshold_ff);
      score_in   = ffpc_pkg::rule_score(rule_ff);
   end

   always_ff @(posedge clock) begin
      if (ready3 && v2_ff) begin
         flag_ff  <= flag_in;
         score_ff <= score_in;
      end
   end

   assign rsp_tvalid   = v3_ff;
   assign rsp_tdata    = score_ff;
   assign rsp_tuser[0] = flag_ff;

   // -------------------------------------------------------------------------
   // Assertions
   // -------------------------------------------------------------------------
   a_flag_has_score: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata != '0)
      else $error("fire flag set with zero score");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !v1_ff && !v2_ff)
      else $error("pipeline not empty after reset");

   a_stage_advance: assert property (@(posedge clock) disable iff (reset)
      v2_ff && ready3 |=> v3_ff)
      else $error("stage 2 item lost on advance");

   a_stall_holds_mid: assert property (@(posedge clock) disable iff (reset)
      v2_ff && !ready3 |=> v2_ff && $stable(rule_ff))
      else $error("stage 2 item changed under stall");

endmodule
